FILE: rtl/meg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meg_pkg: shared widths and codes of the midpoint ellipse generator
// Field widths, stream packing offsets and the request kind codes.
// ----------------------------------------------------------------------------
package meg_pkg;

   // coordinate width of the center inputs
   localparam int COORD_BITS = 12;

   // field widths
   localparam int CEN_W  = COORD_BITS;
   localparam int RAD_W  = COORD_BITS - 1;
   localparam int OUT_W  = COORD_BITS + 2;
   localparam int SQ_W   = 2 * RAD_W;            // squared radius
   localparam int CMP_W  = SQ_W + RAD_W;         // r^2 * offset
   localparam int TMP_W  = 2 * RAD_W + 2;        // (2x+1)^2 or (y-1)^2
   localparam int MUL_W  = 2 * RAD_W + 3;        // signed multiplier operand
   localparam int PROD_W = 2 * MUL_W;
   localparam int DEC_W  = 4 * COORD_BITS;       // decision value, scaled by 4

   // request tdata packing, lowest bits first
   localparam int REQ_CX_LO   = 0;
   localparam int REQ_CY_LO   = REQ_CX_LO + CEN_W;
   localparam int REQ_RX_LO   = REQ_CY_LO + CEN_W;
   localparam int REQ_RY_LO   = REQ_RX_LO + RAD_W;
   localparam int REQ_BITS    = REQ_RY_LO + RAD_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // response tdata packing, lowest bits first
   localparam int RSP_BITS    = 4 * OUT_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // request kind codes carried on tuser
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/meg_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meg_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module meg_mul (
   input  wire logic                               clock,
   input  wire logic signed [meg_pkg::MUL_W-1:0]   a_in,
   input  wire logic signed [meg_pkg::MUL_W-1:0]   b_in,
   output logic signed      [meg_pkg::PROD_W-1:0]  product
);
   import meg_pkg::*;

   logic signed [PROD_W-1:0] product_ff;

   // register the product
   always_ff @(posedge clock) begin
      product_ff <= a_in * b_in;
   end

   assign product = product_ff;

endmodule
`default_nettype wire

FILE: rtl/midpoint_ellipse_generator.sv
`default_nettype none
// Sequencing: a start squares the radii and builds the decision value; a step in region
// one compares first, and the step that changes region rebuilds the decision; a step in
// region two updates at once; an unloaded step answers empty; all share one multiplier.
// Throughput: one request at a time; the next is taken the cycle after the answer
// is handed to the response register, which holds it while the sink stalls.
// Reset: synchronous, active high; clears the sequencer, the loaded flag and rsp_tvalid.
// ----------------------------------------------------------------------------
// midpoint_ellipse_generator: midpoint ellipse point walker
// Loads a center and two radii on a start request, then returns one point
// with its four mirrored coordinates on each step request while the ellipse is loaded,
// walking region one and region two of the midpoint ellipse with an exact decision value.
// ----------------------------------------------------------------------------
module midpoint_ellipse_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [meg_pkg::REQ_DATA_W-1:0]     req_tdata,  // center_x, center_y, radius_x, radius_y
   input  wire logic                               req_tuser,  // kind
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [meg_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // right_x, left_x, lower_y, upper_y
   output logic                                    rsp_tuser,  // point_valid
   output logic                                    rsp_tlast   // last_point
);
   import meg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_INI1, ST_INI2,
      ST_CMP1, ST_CMP2, ST_CMP3,
      ST_R2A, ST_R2B, ST_R2C, ST_R2D, ST_R2E,
      ST_UPD1, ST_UPD2, ST_UPD3, ST_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [CEN_W-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0]         rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_W-1:0]          rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [RAD_W-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [DEC_W-1:0]  dec_ff, dec_in;
   logic                     region_ff, region_in;
   logic                     active_ff, active_in;
   logic                     branch_ff, branch_in;
   logic [CMP_W-1:0]         cmp_ff, cmp_in;
   logic [TMP_W-1:0]         tmp_ff, tmp_in;
   logic [RSP_DATA_W-1:0]    res_data_ff, res_data_in;
   logic                     res_point_ff, res_point_in;
   logic                     res_last_ff, res_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [MUL_W-1:0]  x_ext, y_ext, two_x1, two_x3, y_m1, three_m2y, x_p1;
   logic signed [DEC_W-1:0]  prod_d;
   logic                     req_fire, out_free, y_dec, x_inc;
   logic [OUT_W-1:0]         right_x, left_x, lower_y, upper_y;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared multiplier
   meg_mul u_mul (
      .clock   (clock),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .product (product)
   );

   // offset terms fed to the multiplier
   assign x_ext     = $signed(MUL_W'(x_ff));
   assign y_ext     = $signed(MUL_W'(y_ff));
   assign two_x1    = (x_ext <<< 1) + MUL_W'(1);
   assign two_x3    = (x_ext <<< 1) + MUL_W'(3);
   assign y_m1      = y_ext - MUL_W'(1);
   assign three_m2y = MUL_W'(3) - (y_ext <<< 1);
   assign x_p1      = x_ext + MUL_W'(1);
   assign prod_d    = product[DEC_W-1:0];

   // mirrored coordinates of the current point
   assign right_x = OUT_W'(cx_ff) + OUT_W'(x_ff);
   assign left_x  = OUT_W'(cx_ff) - OUT_W'(x_ff);
   assign lower_y = OUT_W'(cy_ff) + OUT_W'(y_ff);
   assign upper_y = OUT_W'(cy_ff) - OUT_W'(y_ff);

   // step moves: x always advances in region one, y always drops in region two
   assign y_dec = region_ff ? 1'b1 : branch_ff;
   assign x_inc = region_ff ? branch_ff : 1'b1;

   // select multiplier operands per sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = $signed(MUL_W'(rx_ff));
            mul_b = $signed(MUL_W'(rx_ff));
         end
         ST_SQY: begin
            mul_a = $signed(MUL_W'(ry_ff));
            mul_b = $signed(MUL_W'(ry_ff));
         end
         ST_INI1: begin
            mul_a = $signed(MUL_W'(rx2_ff));
            mul_b = $signed(MUL_W'(ry_ff));
         end
         ST_CMP1: begin
            mul_a = $signed(MUL_W'(ry2_ff));
            mul_b = x_ext;
         end
         ST_CMP2: begin
            mul_a = $signed(MUL_W'(rx2_ff));
            mul_b = y_ext;
         end
         ST_CMP3: begin
            mul_a = two_x1;
            mul_b = two_x1;
         end
         ST_R2A: begin
            mul_a = y_m1;
            mul_b = y_m1;
         end
         ST_R2B: begin
            mul_a = $signed(MUL_W'(ry2_ff));
            mul_b = $signed(MUL_W'(tmp_ff));
         end
         ST_R2C: begin
            mul_a = $signed(MUL_W'(rx2_ff));
            mul_b = $signed(MUL_W'(tmp_ff));
         end
         ST_R2D: begin
            mul_a = $signed(MUL_W'(rx2_ff));
            mul_b = $signed(MUL_W'(ry2_ff));
         end
         ST_UPD1: begin
            mul_a = region_ff ? $signed(MUL_W'(rx2_ff)) : $signed(MUL_W'(ry2_ff));
            mul_b = region_ff ? three_m2y : two_x3;
         end
         ST_UPD2: begin
            mul_a = region_ff ? $signed(MUL_W'(ry2_ff)) : $signed(MUL_W'(rx2_ff));
            mul_b = region_ff ? x_p1 : y_m1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dec_in       = dec_ff;
      region_in    = region_ff;
      active_in    = active_ff;
      branch_in    = branch_ff;
      cmp_in       = cmp_ff;
      tmp_in       = tmp_ff;
      res_data_in  = res_data_ff;
      res_point_in = res_point_ff;
      res_last_in  = res_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_START) begin
                  cx_in     = req_tdata[REQ_CX_LO +: CEN_W];
                  cy_in     = req_tdata[REQ_CY_LO +: CEN_W];
                  rx_in     = req_tdata[REQ_RX_LO +: RAD_W];
                  ry_in     = req_tdata[REQ_RY_LO +: RAD_W];
                  x_in      = '0;
                  y_in      = req_tdata[REQ_RY_LO +: RAD_W];
                  region_in = 1'b0;
                  active_in = 1'b1;
                  state_in  = ST_SQX;
               end else if (active_ff) begin
                  state_in = region_ff ? ST_UPD1 : ST_CMP1;
               end else begin
                  res_data_in  = '0;
                  res_point_in = 1'b0;
                  res_last_in  = 1'b0;
                  state_in     = ST_OUT;
               end
            end
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rx2_in   = product[SQ_W-1:0];
            state_in = ST_INI1;
         end
         ST_INI1: begin
            // 4*ry^2 + rx^2
            ry2_in   = product[SQ_W-1:0];
            dec_in   = (prod_d <<< 2) + $signed(DEC_W'(rx2_ff));
            state_in = ST_INI2;
         end
         ST_INI2: begin
            // subtract 4*rx^2*ry, answer with an empty result
            dec_in       = dec_ff - (prod_d <<< 2);
            res_data_in  = '0;
            res_point_in = 1'b0;
            res_last_in  = 1'b0;
            state_in     = ST_OUT;
         end
         ST_CMP1: begin
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            cmp_in   = product[CMP_W-1:0];
            state_in = ST_CMP3;
         end
         ST_CMP3: begin
            // leave region one once ry^2*x exceeds rx^2*y
            if (cmp_ff > product[CMP_W-1:0]) begin
               region_in = 1'b1;
               state_in  = ST_R2A;
            end else begin
               state_in = ST_UPD1;
            end
         end
         ST_R2A: begin
            tmp_in   = product[TMP_W-1:0];
            state_in = ST_R2B;
         end
         ST_R2B: begin
            tmp_in   = product[TMP_W-1:0];
            state_in = ST_R2C;
         end
         ST_R2C: begin
            dec_in   = prod_d;
            state_in = ST_R2D;
         end
         ST_R2D: begin
            dec_in   = dec_ff + (prod_d <<< 2);
            state_in = ST_R2E;
         end
         ST_R2E: begin
            dec_in   = dec_ff - (prod_d <<< 2);
            state_in = ST_UPD1;
         end
         ST_UPD1: begin
            // pick the move from the decision before the update
            branch_in = region_ff ? (dec_ff[DEC_W-1] || (dec_ff == '0)) : !dec_ff[DEC_W-1];
            state_in  = ST_UPD2;
         end
         ST_UPD2: begin
            dec_in   = dec_ff + (prod_d <<< 2);
            state_in = ST_UPD3;
         end
         ST_UPD3: begin
            if (branch_ff) begin
               dec_in = region_ff ? dec_ff + (prod_d <<< 3) : dec_ff - (prod_d <<< 3);
            end
            res_data_in  = RSP_DATA_W'({upper_y, lower_y, left_x, right_x});
            res_point_in = 1'b1;
            res_last_in  = y_dec && (y_ff == '0);
            if (x_inc) begin
               x_in = x_ff + RAD_W'(1);
            end
            if (y_dec) begin
               y_in = y_ff - RAD_W'(1);
            end
            if (y_dec && (y_ff == '0)) begin
               active_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register: load when free, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data_ff;
         rsp_user_in  = res_point_ff;
         rsp_last_in  = res_last_ff;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         region_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rx2_ff       <= rx2_in;
      ry2_ff       <= ry2_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      dec_ff       <= dec_in;
      branch_ff    <= branch_in;
      cmp_ff       <= cmp_in;
      tmp_ff       <= tmp_in;
      res_data_ff  <= res_data_in;
      res_point_ff <= res_point_in;
      res_last_ff  <= res_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

FILE: rtl/meg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meg_checker: port checks of the midpoint ellipse generator
// Watches the request and response channels and flags illegal sequences.
// ----------------------------------------------------------------------------
module meg_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [meg_pkg::REQ_DATA_W-1:0]  req_tdata,  // center_x, center_y, radius_x, radius_y
   input  wire logic                            req_tuser,  // kind
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [meg_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // right_x, left_x, lower_y, upper_y
   input  wire logic                            rsp_tuser,  // point_valid
   input  wire logic                            rsp_tlast   // last_point
);
   import meg_pkg::*;

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != '0 || req_tuser || !req_tuser);

   // after reset: empty response register, ready for a request
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response valid or request not ready after reset");

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // one request at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request accepted while the previous one is in work");

   // the final point is always a real point
   a_last_is_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last flag on a response without a point");

   // a response without a point carries all zero fields
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("response without a point has nonzero fields");

endmodule

bind midpoint_ellipse_generator meg_checker u_meg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the midpoint ellipse generator
// Sends start and step requests, predicts each response from an internal copy
// of the point walker (exact decision value scaled by 4), and compares every
// response field in order. Runs with no backpressure, with source gaps, with
// sink stalls and with both, and drains the response queue between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import meg_pkg::*;

   // one response as the walker should produce it
   typedef struct packed {
      logic [OUT_W-1:0] right_x;
      logic [OUT_W-1:0] left_x;
      logic [OUT_W-1:0] lower_y;
      logic [OUT_W-1:0] upper_y;
      logic             point_valid;
      logic             last_point;
   } ellipse_point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // center_x, center_y, radius_x, radius_y
   logic                  req_tuser = KIND_START;  // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // right_x, left_x, lower_y, upper_y
   logic                  rsp_tuser;   // point_valid
   logic                  rsp_tlast;   // last_point

   // walker state mirrored on the bench side
   longint walk_x, walk_y, walk_decision;
   longint held_cx, held_cy, held_rx, held_ry;
   bit     in_region_two;
   bit     ellipse_loaded;

   ellipse_point_type expected_points[$];
   ellipse_point_type want_point, got_point;
   int                error_count = 0;
   int                items_sent = 0;
   int                source_idle_pct = 0;
   int                sink_stall_pct = 0;

   midpoint_ellipse_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // advance the mirrored walker by one request and return its point
   function automatic ellipse_point_type predict_point(
      input logic             kind,
      input logic [CEN_W-1:0] cx,
      input logic [CEN_W-1:0] cy,
      input logic [RAD_W-1:0] rx,
      input logic [RAD_W-1:0] ry
   );
      ellipse_point_type pt;
      longint            rx2, ry2;
      pt = '0;
      if (kind == KIND_START) begin
         held_cx = longint'(cx);
         held_cy = longint'(cy);
         held_rx = longint'(rx);
         held_ry = longint'(ry);
         rx2 = held_rx * held_rx;
         ry2 = held_ry * held_ry;
         walk_x = 0;
         walk_y = held_ry;
         walk_decision = 4 * ry2 - 4 * rx2 * held_ry + rx2;
         in_region_two = 1'b0;
         ellipse_loaded = 1'b1;
         return pt;
      end
      if (!ellipse_loaded)
         return pt;

      rx2 = held_rx * held_rx;
      ry2 = held_ry * held_ry;

      // switch to region two once the slope passes -1
      if (!in_region_two && ry2 * walk_x > rx2 * walk_y) begin
         in_region_two = 1'b1;
         walk_decision = ry2 * (2 * walk_x + 1) * (2 * walk_x + 1)
                       + 4 * rx2 * (walk_y - 1) * (walk_y - 1)
                       - 4 * rx2 * ry2;
      end

      pt.right_x     = OUT_W'(held_cx + walk_x);
      pt.left_x      = OUT_W'(held_cx - walk_x);
      pt.lower_y     = OUT_W'(held_cy + walk_y);
      pt.upper_y     = OUT_W'(held_cy - walk_y);
      pt.point_valid = 1'b1;

      if (!in_region_two) begin
         if (walk_decision < 0) begin
            walk_decision += 4 * ry2 * (2 * walk_x + 3);
         end else begin
            walk_decision += 4 * ry2 * (2 * walk_x + 3) - 8 * rx2 * (walk_y - 1);
            walk_y--;
         end
         walk_x++;
      end else begin
         if (walk_decision > 0) begin
            walk_decision += 4 * rx2 * (3 - 2 * walk_y);
         end else begin
            walk_decision += 8 * ry2 * (walk_x + 1) + 4 * rx2 * (3 - 2 * walk_y);
            walk_x++;
         end
         walk_y--;
      end

      // drop to idle after the final point
      if (walk_y < 0) begin
         pt.last_point  = 1'b1;
         ellipse_loaded = 1'b0;
      end
      return pt;
   endfunction

   // present one request, hold it until accepted, then queue its point
   task automatic send_request(
      input logic             kind,
      input logic [CEN_W-1:0] cx,
      input logic [CEN_W-1:0] cy,
      input logic [RAD_W-1:0] rx,
      input logic [RAD_W-1:0] ry
   );
      if ($urandom_range(0, 99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < source_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({ry, rx, cy, cx});
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(predict_point(kind, cx, cy, rx, ry));
      items_sent++;
   endtask

   // step request with junk in the unused data bits
   task automatic send_step();
      send_request(KIND_STEP, CEN_W'($urandom_range(0, 4095)),
                   CEN_W'($urandom_range(0, 4095)),
                   RAD_W'($urandom_range(0, 2047)), RAD_W'($urandom_range(0, 2047)));
   endtask

   // step until the ellipse ends or the step budget runs out
   task automatic walk_ellipse(input int max_steps);
      int steps;
      steps = 0;
      while (ellipse_loaded && steps < max_steps) begin
         send_step();
         steps++;
      end
   endtask

   // hold the source off until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic test_step_unloaded();
      send_step();
      send_step();
   endtask

   task automatic test_field_extremes();
      send_request(KIND_START, 12'd4095, 12'd4095, 11'd2047, 11'd2047);
      walk_ellipse(2);
      send_request(KIND_START, 12'd0, 12'd0, 11'd2047, 11'd1);
      walk_ellipse(2);
      send_request(KIND_START, 12'd0, 12'd4095, 11'd1, 11'd2047);
      walk_ellipse(1);
   endtask

   task automatic test_degenerate_radii();
      send_request(KIND_START, 12'd100, 12'd200, 11'd0, 11'd0);
      walk_ellipse(1_000_000);
      send_step();
      send_request(KIND_START, 12'd4095, 12'd0, 11'd0, 11'd3);
      walk_ellipse(1_000_000);
      send_request(KIND_START, 12'd0, 12'd4095, 11'd3, 11'd0);
      walk_ellipse(1_000_000);
   endtask

   // small ellipse walked through both regions to its final point
   task automatic test_full_ellipse();
      send_request(KIND_START, 12'd2048, 12'd2048, 11'd5, 11'd3);
      walk_ellipse(1_000_000);
   endtask

   // random ellipses, mostly walked to the end, some cut short, some noise
   task automatic test_random_walks(input int item_budget);
      int               stop_at;
      int               pick;
      logic [RAD_W-1:0] rx, ry;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_step();
         end else begin
            if (pick < 18) begin
               rx = RAD_W'($urandom_range(0, 2047));
               ry = RAD_W'($urandom_range(0, 2047));
            end else if (pick < 22) begin
               rx = RAD_W'($urandom_range(0, 2047));
               ry = RAD_W'($urandom_range(0, 6));
            end else if (pick < 26) begin
               rx = RAD_W'($urandom_range(0, 6));
               ry = RAD_W'($urandom_range(0, 2047));
            end else begin
               rx = RAD_W'($urandom_range(0, 24));
               ry = RAD_W'($urandom_range(0, 24));
            end
            send_request(KIND_START, CEN_W'($urandom_range(0, 4095)),
                         CEN_W'($urandom_range(0, 4095)), rx, ry);
            if (pick < 26 || $urandom_range(0, 99) < 15) begin
               walk_ellipse($urandom_range(0, 30));
            end else begin
               walk_ellipse(1_000_000);
               if ($urandom_range(0, 4) == 0)
                  send_step();
            end
         end
      end
   endtask

   // report one field mismatch
   task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // sink side: stall at the phase rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // check each accepted response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_point.right_x     = rsp_tdata[OUT_W-1:0];
         got_point.left_x      = rsp_tdata[2*OUT_W-1:OUT_W];
         got_point.lower_y     = rsp_tdata[3*OUT_W-1:2*OUT_W];
         got_point.upper_y     = rsp_tdata[4*OUT_W-1:3*OUT_W];
         got_point.point_valid = rsp_tuser;
         got_point.last_point  = rsp_tlast;
         if (expected_points.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want_point = expected_points.pop_front();
            compare_field("right_x", want_point.right_x, got_point.right_x);
            compare_field("left_x", want_point.left_x, got_point.left_x);
            compare_field("lower_y", want_point.lower_y, got_point.lower_y);
            compare_field("upper_y", want_point.upper_y, got_point.upper_y);
            compare_field("point_valid", OUT_W'(want_point.point_valid),
                          OUT_W'(got_point.point_valid));
            compare_field("last_point", OUT_W'(want_point.last_point),
                          OUT_W'(got_point.last_point));
         end
      end
   end

   // main sequence
   initial begin
      ellipse_loaded = 1'b0;
      in_region_two  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_step_unloaded();
      test_field_extremes();
      test_degenerate_radii();
      test_full_ellipse();
      drain_responses();

      source_idle_pct = 0;
      sink_stall_pct  = 0;
      test_random_walks(320);
      drain_responses();

      source_idle_pct = 48;
      sink_stall_pct  = 0;
      test_random_walks(320);
      drain_responses();

      source_idle_pct = 0;
      sink_stall_pct  = 48;
      test_random_walks(320);
      drain_responses();

      source_idle_pct = 28;
      sink_stall_pct  = 28;
      test_random_walks(320);
      drain_responses();

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog on a hung handshake
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
